// ===== hdl/p2pq_pkg.sv =====
package p2pq_pkg;

    localparam int ROT_W      = 16;
    localparam int POS_W      = 32;
    localparam int FRAC       = 14;
    localparam int ONE        = 1 << FRAC;

    // radicand a is below 2^19, a*ONE below 2^33, sqrt below 2^17
    localparam int RAD_W      = 34;
    localparam int SQRT_W     = 18;
    localparam int SQRT_STEPS = RAD_W / 2;

    // difference magnitude below 2^17, shifted by FRAC
    localparam int DIFF_W     = 18;
    localparam int NUM_W      = DIFF_W + FRAC + 1;
    localparam int DEN_W      = SQRT_W + 1;
    localparam int QUO_W      = NUM_W;

    localparam int PROD_W     = ROT_W + POS_W;
    localparam int ACC_W      = PROD_W + 2;

    typedef logic signed [ROT_W-1:0] rot_t;
    typedef logic signed [POS_W-1:0] pos_t;

    // one root iteration: remainder, partial root, radicand bits left
    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [SQRT_W:0]  root;
        logic [RAD_W-1:0] rad;
    } sqrt_st_t;

    function automatic logic signed [ROT_W-1:0] quat_sat(
        input logic signed [QUO_W:0] v
    );
        logic signed [QUO_W:0] lim;
        begin
            lim = (QUO_W+1)'(ONE);
            if (v > lim)
                quat_sat = ROT_W'(ONE);
            else if (v < -lim)
                quat_sat = ROT_W'(-ONE);
            else
                quat_sat = v[ROT_W-1:0];
        end
    endfunction

endpackage

// ===== hdl/pose_to_position_quaternion.sv =====
// Pose to camera position and orientation quaternion.
// Input channel: in_valid/in_stall with nine Q1.14 rotation entries rot_rc
// and a Q16.16 translation. Output channel: out_valid/out_stall with the
// saturated Q16.16 camera position -R^T*t and the Q1.14 quaternion of R^T
// (trace method, largest-diagonal fallback).
// Throughput: one transaction per cycle unless a stalled output holds the
// pipe. Depth: 53 register stages in all: two setup stages (products, then
// sums and radicand), the root pipeline (one stage per radicand bit pair,
// 17), the divider (one stage per quotient bit, 33) and the output register.
// The whole pipe advances together; a stall on the output freezes every
// stage. in_stall is high exactly when a result waits on a stalled output;
// bubbles inside the pipe are not squeezed out.
// Reset clears all valid bits; payload registers are not reset.
module pose_to_position_quaternion (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [15:0] rot_00, rot_01, rot_02,
    input  logic signed [15:0] rot_10, rot_11, rot_12,
    input  logic signed [15:0] rot_20, rot_21, rot_22,
    input  logic signed [31:0] trans_x, trans_y, trans_z,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] pos_x, pos_y, pos_z,
    output logic signed [15:0] quat_x, quat_y, quat_z, quat_w
);
    localparam int DEPTH = p2pq_pkg::SQRT_STEPS + p2pq_pkg::QUO_W + 1;
    localparam int FR    = p2pq_pkg::FRAC;
    localparam int AW    = p2pq_pkg::ACC_W;

    logic adv;
    logic [DEPTH+1:0] vld_reg;
    assign adv      = !out_valid || !out_stall;
    assign in_stall = !adv;

    // stage 1: transpose, products, case select
    logic signed [15:0] m [3][3];
    assign m[0][0]=rot_00; assign m[1][0]=rot_01; assign m[2][0]=rot_02;
    assign m[0][1]=rot_10; assign m[1][1]=rot_11; assign m[2][1]=rot_12;
    assign m[0][2]=rot_20; assign m[1][2]=rot_21; assign m[2][2]=rot_22;
    logic signed [31:0] t [3];
    assign t[0]=trans_x; assign t[1]=trans_y; assign t[2]=trans_z;

    logic signed [p2pq_pkg::PROD_W-1:0] prod_reg [3][3];
    logic [1:0] big_reg;
    logic       pos_tr_reg;
    logic signed [15:0] m_reg [3][3];

    logic signed [17:0] trace;
    logic [1:0] big;
    always_comb
    begin
        trace = 18'(m[0][0]) + 18'(m[1][1]) + 18'(m[2][2]);
        if (m[0][0] < m[1][1])
            big = (m[1][1] < m[2][2]) ? 2'd2 : 2'd1;
        else
            big = (m[0][0] < m[2][2]) ? 2'd2 : 2'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= m[r][c] * t[c];
                    m_reg[r][c]    <= m[r][c];
                end
            big_reg    <= big;
            pos_tr_reg <= trace > 0;
        end
    end

    // stage 2: sums, radicand, differences
    logic signed [AW-1:0] acc_reg [3];
    logic [p2pq_pkg::RAD_W-1:0] rad;
    logic [2:0][p2pq_pkg::DIFF_W:0] dif;
    logic [2:0] slot;   // bit 0 flags the positive-trace layout
    logic [1:0] bslot;  // slot of the root component
    always_comb
    begin
        logic signed [19:0] a;
        logic [1:0] i, j, k;
        i = big_reg;
        j = (big_reg == 2'd2) ? 2'd0 : big_reg + 2'd1;
        k = (big_reg == 2'd0) ? 2'd2 : big_reg - 2'd1;
        if (pos_tr_reg)
        begin
            a = 20'(m_reg[0][0]) + 20'(m_reg[1][1]) + 20'(m_reg[2][2]) + 20'(p2pq_pkg::ONE);
            dif[0] = 19'(m_reg[2][1]) - 19'(m_reg[1][2]);
            dif[1] = 19'(m_reg[0][2]) - 19'(m_reg[2][0]);
            dif[2] = 19'(m_reg[1][0]) - 19'(m_reg[0][1]);
            bslot = 2'd3;
        end
        else
        begin
            a = 20'(m_reg[i][i]) - 20'(m_reg[j][j]) - 20'(m_reg[k][k])
              + 20'(p2pq_pkg::ONE);
            if (a < 20'sd1)
                a = 20'sd1;
            dif[0] = 19'(m_reg[k][j]) - 19'(m_reg[j][k]);
            dif[1] = 19'(m_reg[j][i]) + 19'(m_reg[i][j]);
            dif[2] = 19'(m_reg[k][i]) + 19'(m_reg[i][k]);
            bslot = big_reg;
        end
        rad  = p2pq_pkg::RAD_W'(a) << FR;
        slot = 3'(pos_tr_reg);
    end

    logic [p2pq_pkg::RAD_W-1:0] rad_reg;
    logic [2:0][p2pq_pkg::DIFF_W:0] dif_reg;
    logic [1:0] bs_pipe [DEPTH];
    logic [2:0] sl_pipe [DEPTH];
    logic signed [31:0] pos_pipe [DEPTH-1][3];
    logic signed [31:0] pos_n [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            logic signed [AW-1:0] s;
            s = -acc_reg[r] + AW'(1 << (FR-1));
            s = s >>> FR;
            if (s > AW'(32'sh7fffffff))
                pos_n[r] = 32'sh7fffffff;
            else if (s < -AW'(64'sh80000000))
                pos_n[r] = 32'sh80000000;
            else
                pos_n[r] = s[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
                acc_reg[r] <= AW'(prod_reg[r][0]) + AW'(prod_reg[r][1])
                            + AW'(prod_reg[r][2]);
            rad_reg    <= rad;
            dif_reg    <= dif;
            bs_pipe[0] <= bslot;
            sl_pipe[0] <= {2'b00, slot[0]};
            for (int r = 0; r < 3; r++)
                pos_pipe[0][r] <= pos_n[r];
            for (int d = 1; d < DEPTH; d++)
            begin
                bs_pipe[d]  <= bs_pipe[d-1];
                sl_pipe[d]  <= sl_pipe[d-1];
            end
            for (int d = 1; d < DEPTH - 1; d++)
                pos_pipe[d] <= pos_pipe[d-1];
        end
    end

    // note: pos_pipe[0] is loaded one stage after acc, so it runs one entry
    // shorter than bs_pipe to line up with the core output
    logic [p2pq_pkg::SQRT_W-1:0] root;
    logic signed [2:0][p2pq_pkg::QUO_W:0] quo;
    p2pq_sqrt_div u_core (
        .clk  (clk),
        .rst_n(rst_n),
        .adv  (adv),
        .rad  (rad_reg),
        .diff (dif_reg),
        .root (root),
        .quo  (quo)
    );

    // output assembly; the root component saturates like the others
    logic signed [15:0] q_n [4];
    always_comb
    begin
        logic signed [15:0] hb;
        logic signed [15:0] q1;
        logic signed [15:0] q2;
        logic [1:0] bi, bj;
        hb = p2pq_pkg::quat_sat((p2pq_pkg::QUO_W+1)'((root + 18'd1) >> 1));
        q1 = p2pq_pkg::quat_sat(quo[1]);
        q2 = p2pq_pkg::quat_sat(quo[2]);
        bi = bs_pipe[DEPTH-1];
        bj = (bi == 2'd2) ? 2'd0 : bi + 2'd1;
        if (sl_pipe[DEPTH-1][0])
        begin
            q_n[0] = p2pq_pkg::quat_sat(quo[0]);
            q_n[1] = q1;
            q_n[2] = q2;
            q_n[3] = hb;
        end
        else
        begin
            q_n[3] = p2pq_pkg::quat_sat(quo[0]);
            for (int n = 0; n < 3; n++)
            begin
                if (2'(n) == bi)
                    q_n[n] = hb;
                else if (2'(n) == bj)
                    q_n[n] = q1;
                else
                    q_n[n] = q2;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pos_x  <= pos_pipe[DEPTH-2][0];
            pos_y  <= pos_pipe[DEPTH-2][1];
            pos_z  <= pos_pipe[DEPTH-2][2];
            quat_x <= q_n[0];
            quat_y <= q_n[1];
            quat_z <= q_n[2];
            quat_w <= q_n[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH:0], in_valid};
    end
    assign out_valid = vld_reg[DEPTH+1];
endmodule

// ===== hdl/p2pq_sqrt_div.sv =====
// Pipelined rounded square root and three signed rounded divides by 2*S.
// One stage per root bit, then one stage per quotient bit.
module p2pq_sqrt_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  logic [p2pq_pkg::RAD_W-1:0]      rad,
    input  logic [2:0][p2pq_pkg::DIFF_W:0]  diff,
    output logic [p2pq_pkg::SQRT_W-1:0]     root,
    output logic signed [2:0][p2pq_pkg::QUO_W:0] quo
);
    localparam int RS = p2pq_pkg::SQRT_STEPS;
    localparam int QS = p2pq_pkg::QUO_W;
    localparam int NW = p2pq_pkg::NUM_W;
    localparam int DW = p2pq_pkg::DEN_W;

    p2pq_pkg::sqrt_st_t          sq_reg [RS+1];
    logic [2:0][p2pq_pkg::DIFF_W:0] sd_reg [RS+1];

    assign sq_reg[0] = '{rem: '0, root: '0, rad: rad};
    assign sd_reg[0] = diff;

    // root stages: digit-by-digit, two radicand bits each
    for (genvar g = 0; g < RS; g++)
    begin : g_root
        p2pq_pkg::sqrt_st_t nx;
        logic [p2pq_pkg::RAD_W-1:0] trial;
        logic [p2pq_pkg::RAD_W-1:0] rem2;
        always_comb
        begin
            rem2  = {sq_reg[g].rem[p2pq_pkg::RAD_W-3:0],
                     sq_reg[g].rad[p2pq_pkg::RAD_W-1 -: 2]};
            trial = {(p2pq_pkg::RAD_W-p2pq_pkg::SQRT_W-3)'(0), sq_reg[g].root, 2'b01};
            nx.rad = {sq_reg[g].rad[p2pq_pkg::RAD_W-3:0], 2'b00};
            if (rem2 >= trial)
            begin
                nx.rem  = rem2 - trial;
                nx.root = {sq_reg[g].root[p2pq_pkg::SQRT_W-1:0], 1'b1};
            end
            else
            begin
                nx.rem  = rem2;
                nx.root = {sq_reg[g].root[p2pq_pkg::SQRT_W-1:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[g+1] <= nx;
                sd_reg[g+1] <= sd_reg[g];
            end
        end
    end

    // round to nearest: remainder above floor root adds one
    logic [p2pq_pkg::SQRT_W-1:0] s_rnd;
    assign s_rnd = sq_reg[RS].root[p2pq_pkg::SQRT_W-1:0]
                 + p2pq_pkg::SQRT_W'(sq_reg[RS].rem > p2pq_pkg::RAD_W'(sq_reg[RS].root));

    // divide stages, restoring, one quotient bit each
    logic [2:0][NW-1:0] num_reg [QS+1];
    logic [2:0][NW-1:0] rem_reg [QS+1];
    logic [2:0][QS-1:0] q_reg   [QS+1];
    logic [2:0]         neg_reg [QS+1];
    logic [DW-1:0]      den_reg [QS+1];
    logic [p2pq_pkg::SQRT_W-1:0] s_reg [QS+1];

    always_comb
    begin
        den_reg[0] = {s_rnd, 1'b0};
        s_reg[0]   = s_rnd;
        for (int c = 0; c < 3; c++)
        begin
            logic [p2pq_pkg::DIFF_W:0] d;
            logic [p2pq_pkg::DIFF_W:0] mg;
            d  = sd_reg[RS][c];
            mg = d[p2pq_pkg::DIFF_W] ? -d : d;
            neg_reg[0][c] = d[p2pq_pkg::DIFF_W];
            num_reg[0][c] = (NW'(mg) << p2pq_pkg::FRAC) + NW'(s_rnd);
            rem_reg[0][c] = '0;
            q_reg[0][c]   = '0;
        end
    end

    for (genvar g = 0; g < QS; g++)
    begin : g_div
        logic [2:0][NW-1:0] rn;
        logic [2:0][QS-1:0] qn;
        logic [2:0][NW-1:0] numn;
        always_comb
        begin
            for (int c = 0; c < 3; c++)
            begin
                logic [NW:0] r2;
                r2 = {rem_reg[g][c], num_reg[g][c][NW-1]};
                numn[c] = {num_reg[g][c][NW-2:0], 1'b0};
                if (r2 >= (NW+1)'(den_reg[g]))
                begin
                    rn[c] = NW'(r2 - (NW+1)'(den_reg[g]));
                    qn[c] = {q_reg[g][c][QS-2:0], 1'b1};
                end
                else
                begin
                    rn[c] = NW'(r2);
                    qn[c] = {q_reg[g][c][QS-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[g+1] <= numn;
                rem_reg[g+1] <= rn;
                q_reg[g+1]   <= qn;
                neg_reg[g+1] <= neg_reg[g];
                den_reg[g+1] <= den_reg[g];
                s_reg[g+1]   <= s_reg[g];
            end
        end
    end

    assign root = s_reg[QS];
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            quo[c] = neg_reg[QS][c] ? -$signed({1'b0, q_reg[QS][c]})
                                    :  $signed({1'b0, q_reg[QS][c]});
        end
    end

    logic unused_rst;
    assign unused_rst = rst_n;
endmodule

// ===== hdl/p2pq_checker.sv =====
module p2pq_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic signed [15:0] quat_w
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output dropped under stall");
    a_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quat_w <= 16'sd16384 && quat_w >= -16'sd16384)
        else $error("quat_w out of range");
endmodule

bind pose_to_position_quaternion p2pq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .quat_w(quat_w)
);
